// ----- sv/chacha_pkg.sv -----
// Shared types, constants and helper functions for the ChaCha20 stream cipher.
`default_nettype none

package chacha_pkg;

    // Number of double rounds in one keystream block (range 4 to 10).
    localparam int DOUBLE_ROUNDS = 10;

    // Each double round takes eight datapath steps: four for the column round and
    // four for the diagonal round, with the four quarter rounds running side by side.
    localparam int ROUND_STEPS = DOUBLE_ROUNDS * 8;
    localparam int STEP_W      = $clog2(ROUND_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT  = 3'd6;

    // The "expand 32-byte k" constants.
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [31:0] INIT_COUNT_RESET = 32'd1;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } msg_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              new_msg;
        logic              step;
        logic [STEP_W-1:0] step_idx;
        logic              feed;
        logic              consume;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_end;
    } status_t;

    // Rotate amount for each of the four steps of a quarter round.
    function automatic logic [4:0] rot_amount(input logic [1:0] phase);
        logic [4:0] amt;
        case (phase)
            2'd0:    amt = 5'd16;
            2'd1:    amt = 5'd12;
            2'd2:    amt = 5'd8;
            default: amt = 5'd7;
        endcase
        return amt;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] twice;
        twice = {v, v} << n;
        return twice[63:32];
    endfunction

    // Word index of a quarter-round operand: row 0 to 3 selects a, b, c or d.
    // On a diagonal round, row r of lane l comes from column (l + r) mod 4.
    function automatic logic [3:0] word_index(input logic [1:0] lane,
                                              input logic [1:0] row,
                                              input logic       diag);
        logic [1:0] col;
        col = diag ? lane + row : lane;
        return {row, col};
    endfunction

endpackage

`default_nettype wire

// ----- sv/chacha20_stream_cipher.sv -----
// Top level of the ChaCha20 stream cipher: byte stream in, keystream-XORed bytes out.
//
// Usage. Message bytes arrive on the msg channel (msg_valid, msg_ready, msg) one
// beat per byte, with msg.last_in marking the final byte of a message. Each beat
// returns one beat on the res channel (res_valid, res_ready, res) carrying the byte
// XORed with the ChaCha20 keystream and a copy of the last flag.
// The key, nonce and initial block counter are written through the cfg channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// writes to unused indexes are dropped. Write them only while the block is idle.
// Timing. At the first byte of a message and after every 64 bytes, the block
// builds a new keystream block before taking the byte: it loads the start
// words, runs the double rounds in a four-lane quarter-round unit, and adds
// the start words back in a feed-forward step. The other 63 bytes of a block
// are taken at one per cycle while the receiver keeps up, and each result
// appears in the output register the cycle after its beat. No byte is taken
// while the shared round unit builds a block.
// Reset clears the controller and returns the block to the start of a message;
// the configuration registers return to zero, with the initial counter at one.
// When the receiver stalls, the result waits in the output register and the
// next byte is taken as soon as that register is being emptied.
`default_nettype none

module chacha20_stream_cipher
    import chacha_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  msg_valid,
    output logic                       msg_ready,
    input  wire msg_t                  msg,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Register writes are always taken at once.
    assign cfg_ready = 1'b1;

    chacha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_last  (msg.last_in),
        .msg_ready (msg_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .status    (status)
    );

    chacha_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- sv/chacha_ctrl.sv -----
// Controller state machine for the ChaCha20 stream cipher.
`default_nettype none

module chacha_ctrl
    import chacha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    msg_valid,
    input  wire logic    msg_last,
    output logic         msg_ready,
    output logic         res_valid,
    input  wire logic    res_ready,
    output cmd_t         cmd,
    input  wire status_t status
);

    typedef enum logic [1:0] {
        S_WAIT,
        S_ROUND,
        S_FINAL,
        S_STREAM
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              in_msg_reg, in_msg_next;
    logic              res_valid_reg, res_valid_next;
    logic              accept;

    assign msg_ready = (state_reg == S_STREAM) && (!res_valid_reg || res_ready);
    assign accept    = msg_valid && msg_ready;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        in_msg_next    = in_msg_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        cmd.step_idx   = step_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_WAIT:
            begin
                if (msg_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.new_msg = !in_msg_reg;
                    in_msg_next = 1'b1;
                    step_next   = '0;
                    state_next  = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROUND_STEPS - 1))
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.feed   = 1'b1;
                state_next = S_STREAM;
            end
            S_STREAM:
            begin
                if (accept)
                begin
                    cmd.consume    = 1'b1;
                    res_valid_next = 1'b1;
                    if (msg_last)
                    begin
                        in_msg_next = 1'b0;
                        state_next  = S_WAIT;
                    end
                    else if (status.block_end)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WAIT;
            step_reg      <= '0;
            in_msg_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            in_msg_reg    <= in_msg_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/chacha_dp.sv -----
// Datapath for the ChaCha20 stream cipher: registers, round lanes and byte XOR.
`default_nettype none

module chacha_dp
    import chacha_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire msg_t                  msg,
    output res_t                       res,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    logic [63:0] key_reg [4];
    logic [63:0] nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [31:0] init_count_reg;

    logic [31:0] counter_reg, counter_next;
    logic [5:0]  pos_reg;
    logic [31:0] work_reg [16];
    logic [31:0] work_next [16];
    logic [31:0] init_w [16];
    logic [31:0] ctr_use;
    res_t        res_reg;

    logic [1:0]  phase;
    logic        diag;
    logic [4:0]  rot;
    logic [3:0]  xi [4];
    logic [3:0]  yi [4];
    logic [3:0]  zi [4];
    logic [31:0] sum [4];

    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_count_reg <= INIT_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_WORD_0: key_reg[0]     <= cfg_data;
                CFG_KEY_WORD_1: key_reg[1]     <= cfg_data;
                CFG_KEY_WORD_2: key_reg[2]     <= cfg_data;
                CFG_KEY_WORD_3: key_reg[3]     <= cfg_data;
                CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                CFG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                CFG_INIT_COUNT: init_count_reg <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    assign counter_next = cmd.new_msg ? init_count_reg : counter_reg + 32'd1;
    assign ctr_use      = cmd.load ? counter_next : counter_reg;

    always_comb
    begin
        init_w[0] = SIGMA_0;
        init_w[1] = SIGMA_1;
        init_w[2] = SIGMA_2;
        init_w[3] = SIGMA_3;
        for (int k = 0; k < 4; k++)
        begin
            init_w[4 + 2 * k] = key_reg[k][31:0];
            init_w[5 + 2 * k] = key_reg[k][63:32];
        end
        init_w[12] = ctr_use;
        init_w[13] = nonce_low_reg[31:0];
        init_w[14] = nonce_low_reg[63:32];
        init_w[15] = nonce_high_reg;
    end

    // One step of all four quarter rounds: x += y; z ^= x; z <<<= r.
    // Even steps work on (a, b, d), odd steps on (c, d, b).
    assign phase = cmd.step_idx[1:0];
    assign diag  = cmd.step_idx[2];
    assign rot   = rot_amount(phase);

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            xi[l]  = word_index(2'(l), phase[0] ? 2'd2 : 2'd0, diag);
            yi[l]  = word_index(2'(l), phase[0] ? 2'd3 : 2'd1, diag);
            zi[l]  = word_index(2'(l), phase[0] ? 2'd1 : 2'd3, diag);
            sum[l] = work_reg[xi[l]] + work_reg[yi[l]];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            work_next[k] = work_reg[k];
        end
        if (cmd.load)
        begin
            for (int k = 0; k < 16; k++)
            begin
                work_next[k] = init_w[k];
            end
        end
        else if (cmd.step)
        begin
            for (int l = 0; l < 4; l++)
            begin
                work_next[xi[l]] = sum[l];
                work_next[zi[l]] = rotl(work_reg[zi[l]] ^ sum[l], rot);
            end
        end
        else if (cmd.feed)
        begin
            for (int k = 0; k < 16; k++)
            begin
                work_next[k] = work_reg[k] + init_w[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 16; k++)
        begin
            work_reg[k] <= work_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                counter_reg <= counter_next;
                if (cmd.new_msg)
                begin
                    pos_reg <= '0;
                end
            end
            else if (cmd.consume)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end

    assign ks_word = work_reg[pos_reg[5:2]];
    assign ks_byte = 8'(ks_word >> {pos_reg[1:0], 3'b000});

    always_ff @(posedge clk)
    begin
        if (cmd.consume)
        begin
            res_reg.data_out <= msg.data_in ^ ks_byte;
            res_reg.last_out <= msg.last_in;
        end
    end

    assign res              = res_reg;
    assign status.block_end = (pos_reg == 6'd63);

endmodule

`default_nettype wire
